// ===== hdl/address_region_table_unit_assert.svh =====
// Assertion macros for the address region table.
`ifndef ADDRESS_REGION_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_REGION_TABLE_UNIT_ASSERT_SVH

// Property checked on every clock edge while out of reset.
`define ART_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define ART_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/art_pkg.sv =====
// Shared constants and codes for the address region table.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

   // Table size and address width
   localparam int MaxRegions = 16;
   localparam int AddrBits   = 64;

   // Fixed field widths of the channels
   localparam int FieldW  = 64;
   localparam int OpW     = 2;
   localparam int PermW   = 3;
   localparam int StatusW = 3;

   // Derived widths
   localparam int IdxW   = $clog2(MaxRegions);
   localparam int CntW   = $clog2(MaxRegions + 1);
   localparam int EntryW = 2 * AddrBits + PermW;

   typedef enum logic [OpW-1:0] {
      OP_DEFINE  = 2'd0,
      OP_SEEK    = 2'd1,
      OP_DESTROY = 2'd2
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK       = 3'd0,
      ST_OVERLAP  = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOMATCH  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/art_ifs.sv =====
// Request and response channel interfaces of the address region table.
`timescale 1ns / 1ps
`default_nettype none

interface art_req_if;
   logic                       valid;
   logic                       ready;
   logic [art_pkg::OpW-1:0]    opcode;
   logic [art_pkg::FieldW-1:0] address;
   logic [art_pkg::FieldW-1:0] region_size;
   logic [art_pkg::PermW-1:0]  access_perm;

   modport source (output valid, opcode, address, region_size, access_perm,
                   input ready);
   modport sink   (input valid, opcode, address, region_size, access_perm,
                   output ready);
endinterface

interface art_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [art_pkg::StatusW-1:0] status;
   logic [art_pkg::FieldW-1:0]  found_base;
   logic [art_pkg::FieldW-1:0]  found_top;
   logic [art_pkg::PermW-1:0]   found_perm;

   modport source (output valid, status, found_base, found_top, found_perm,
                   input ready);
   modport sink   (input valid, status, found_base, found_top, found_perm,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/art_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module art_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/address_region_table_unit.sv =====
// Address region table: define, seek and destroy of non-overlapping regions.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    opcode, address, region_size, access_perm
//   rsp_ch   out  valid/ready    status, found_base, found_top, found_perm
//
// One request at a time. A define, seek or destroy walks the entry RAM one
// slot per cycle through a single shared range comparator; a hit ends the
// walk early. Overflow and unused opcodes skip the walk. Synchronous reset
// clears the slot valid bits, so the table comes up empty with no clearing
// pass. A response waiting on rsp_ch does not block the next request; a
// request finishing while the previous response is still held stalls until
// it is taken.
`timescale 1ns / 1ps
`default_nettype none

module address_region_table_unit (
   input wire logic   clock,
   input wire logic   reset,
   art_req_if.sink    req_ch,
   art_rsp_if.source  rsp_ch
);

`include "address_region_table_unit_assert.svh"

   localparam int AW = art_pkg::AddrBits;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // Control state
   state_type                    state_ff;
   logic [art_pkg::CntW-1:0]     cnt_ff;
   logic                         rd_vld_ff;
   logic [art_pkg::IdxW-1:0]     rd_idx_ff;
   logic                         free_vld_ff;
   logic [art_pkg::IdxW-1:0]     free_idx_ff;
   logic [art_pkg::IdxW-1:0]     hit_idx_ff;
   logic [art_pkg::MaxRegions-1:0] valid_ff;
   logic                         rsp_valid_ff;

   // Request operands and working result
   logic [art_pkg::OpW-1:0]      op_ff;
   logic [AW-1:0]                lo_ff;
   logic [AW-1:0]                hi_ff;
   logic [art_pkg::PermW-1:0]    perm_ff;
   art_pkg::status_type          status_ff;
   logic [AW-1:0]                fbase_ff;
   logic [AW-1:0]                ftop_ff;
   logic [art_pkg::PermW-1:0]    fperm_ff;

   // Response register
   art_pkg::status_type          rsp_status_ff;
   logic [AW-1:0]                rsp_base_ff;
   logic [AW-1:0]                rsp_top_ff;
   logic [art_pkg::PermW-1:0]    rsp_perm_ff;

   // Combinational signals
   logic [AW-1:0]                req_addr;
   logic [AW-1:0]                req_size;
   logic [AW:0]                  req_sum;
   logic                         accept;
   logic                         issue;
   logic [art_pkg::EntryW-1:0]   rd_data;
   logic [art_pkg::EntryW-1:0]   wr_data;
   logic                         wr_en;
   logic [AW-1:0]                e_base;
   logic [AW-1:0]                e_top;
   logic [art_pkg::PermW-1:0]    e_perm;
   logic                         e_vld;
   logic                         cmp_hit;
   logic                         last_slot;
   logic                         free_now;
   logic                         rsp_load;
   logic                         def_commit;
   logic                         del_commit;

   // Operand prep: upper address bits beyond the table width are ignored
   assign req_addr = req_ch.address[AW-1:0];
   assign req_size = req_ch.region_size[AW-1:0];
   assign req_sum  = {1'b0, req_addr} + {1'b0, req_size};
   assign accept   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Slot walk: one RAM read issued per cycle
   assign issue = (state_ff == S_SCAN) && (cnt_ff < art_pkg::CntW'(art_pkg::MaxRegions));

   art_ram #(
      .Width (art_pkg::EntryW),
      .Depth (art_pkg::MaxRegions)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[art_pkg::IdxW-1:0]),
      .rd_data (rd_data)
   );

   // Shared range comparator: [lo, hi] against the slot read last cycle
   assign {e_base, e_top, e_perm} = rd_data;
   assign e_vld     = valid_ff[rd_idx_ff];
   assign cmp_hit   = e_vld && (lo_ff <= e_top) && (hi_ff >= e_base);
   assign last_slot = (rd_idx_ff == art_pkg::IdxW'(art_pkg::MaxRegions - 1));
   assign free_now  = free_vld_ff || !e_vld;

   // Commit and response handoff
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign def_commit = rsp_load && (status_ff == art_pkg::ST_OK) &&
                       (op_ff == art_pkg::OP_DEFINE);
   assign del_commit = rsp_load && (status_ff == art_pkg::ST_OK) &&
                       (op_ff == art_pkg::OP_DESTROY);
   assign wr_en      = def_commit;
   assign wr_data    = {lo_ff, hi_ff, perm_ff};

   // Sequencer, table valid bits and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         free_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         rd_idx_ff <= cnt_ff[art_pkg::IdxW-1:0];
         // Response taken and no new one loaded this cycle
         if (rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff       <= req_ch.opcode;
                  lo_ff       <= req_addr;
                  perm_ff     <= req_ch.access_perm;
                  cnt_ff      <= '0;
                  free_vld_ff <= 1'b0;
                  fbase_ff    <= '0;
                  ftop_ff     <= '0;
                  fperm_ff    <= '0;
                  case (req_ch.opcode) inside
                     art_pkg::OP_DEFINE: begin
                        hi_ff <= req_sum[AW-1:0];
                        if (req_sum[AW]) begin
                           status_ff <= art_pkg::ST_OVERFLOW;
                           state_ff  <= S_DONE;
                        end else begin
                           status_ff <= art_pkg::ST_FULL;
                           state_ff  <= S_SCAN;
                        end
                     end
                     art_pkg::OP_SEEK, art_pkg::OP_DESTROY: begin
                        hi_ff     <= req_addr;
                        status_ff <= art_pkg::ST_NOMATCH;
                        state_ff  <= S_SCAN;
                     end
                     default: begin
                        hi_ff     <= req_addr;
                        status_ff <= art_pkg::ST_NOMATCH;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end

            S_SCAN: begin
               if (issue) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (rd_vld_ff) begin
                  if (cmp_hit) begin
                     // Lowest matching slot ends the walk
                     if (op_ff == art_pkg::OP_DEFINE) begin
                        status_ff <= art_pkg::ST_OVERLAP;
                     end else begin
                        status_ff  <= art_pkg::ST_OK;
                        fbase_ff   <= e_base;
                        ftop_ff    <= e_top;
                        fperm_ff   <= e_perm;
                        hit_idx_ff <= rd_idx_ff;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     // Remember the lowest free slot for a define
                     if (!e_vld && !free_vld_ff) begin
                        free_vld_ff <= 1'b1;
                        free_idx_ff <= rd_idx_ff;
                     end
                     if (last_slot) begin
                        if (op_ff == art_pkg::OP_DEFINE && free_now) begin
                           status_ff <= art_pkg::ST_OK;
                        end
                        state_ff <= S_DONE;
                     end
                  end
               end
            end

            S_DONE: begin
               if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_base_ff   <= fbase_ff;
                  rsp_top_ff    <= ftop_ff;
                  rsp_perm_ff   <= fperm_ff;
                  if (def_commit) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                  end
                  if (del_commit) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Response channel
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.found_base = art_pkg::FieldW'(rsp_base_ff);
   assign rsp_ch.found_top  = art_pkg::FieldW'(rsp_top_ff);
   assign rsp_ch.found_perm = rsp_perm_ff;

   // Checks
   `ART_ASSERT(a_def_free_slot, def_commit |-> !valid_ff[free_idx_ff], "define into used slot")
   `ART_ASSERT(a_del_live_slot, del_commit |-> valid_ff[hit_idx_ff], "destroy of empty slot")
   `ART_ASSERT(a_def_count, def_commit |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1), "define did not add one region")
   `ART_ASSERT_RST(a_reset_idle, reset |=> (!rsp_valid_ff && state_ff == S_IDLE), "not idle after reset")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the address region table: directed, table-full, backpressure, random.
`timescale 1ns / 1ps

module tb_top;
   import art_pkg::*;

   localparam logic [FieldW-1:0] AddrMask = {FieldW{1'b1}} >> (FieldW - AddrBits);
   localparam logic [OpW-1:0]    OpUnused = 2'd3;
   // One full table walk plus response hand-off, with margin
   localparam int DrainCycles = 3 * (MaxRegions + 3);
   localparam int HoldCycles  = 300;
   localparam int PhaseItems  = 185;
   localparam int MaxPrinted  = 100;

   typedef struct packed {
      status_type         status;
      logic [FieldW-1:0]  base;
      logic [FieldW-1:0]  top;
      logic [PermW-1:0]   perm;
   } region_answer_type;

   logic clock;
   logic reset;

   art_req_if req_if ();
   art_rsp_if rsp_if ();

   address_region_table_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow copy of the region table
   bit                shadow_valid [MaxRegions];
   logic [FieldW-1:0] shadow_base  [MaxRegions];
   logic [FieldW-1:0] shadow_top   [MaxRegions];
   logic [PermW-1:0]  shadow_perm  [MaxRegions];

   region_answer_type expected_answers[$];
   int error_count    = 0;
   int items_sent     = 0;
   int answers_seen   = 0;
   int hold_request   = 0;
   int op_seen[4]     = '{default: 0};
   int status_seen[8] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected answer for one request; updates the shadow table
   function automatic region_answer_type predict_region_op(
      input logic [OpW-1:0]    op,
      input logic [FieldW-1:0] addr_in,
      input logic [FieldW-1:0] size_in,
      input logic [PermW-1:0]  perm
   );
      region_answer_type ans;
      logic [FieldW-1:0] addr;
      logic [FieldW-1:0] size;
      logic [FieldW-1:0] top;
      logic [FieldW:0]   sum;
      int                free_slot;
      int                hit;
      ans       = '{status: ST_NOMATCH, base: '0, top: '0, perm: '0};
      addr      = addr_in & AddrMask;
      size      = size_in & AddrMask;
      free_slot = -1;
      hit       = -1;
      if (op == OP_DEFINE) begin
         sum = {1'b0, addr} + {1'b0, size};
         top = sum[FieldW-1:0];
         // overflow beats overlap, overlap beats full
         if (sum[FieldW] || top > AddrMask) begin
            ans.status = ST_OVERFLOW;
         end else begin
            ans.status = ST_OK;
            for (int i = 0; i < MaxRegions; i++) begin
               if (shadow_valid[i]) begin
                  if (addr <= shadow_top[i] && top >= shadow_base[i])
                     ans.status = ST_OVERLAP;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (ans.status == ST_OK && free_slot < 0)
               ans.status = ST_FULL;
            if (ans.status == ST_OK) begin
               shadow_valid[free_slot] = 1'b1;
               shadow_base[free_slot]  = addr;
               shadow_top[free_slot]   = top;
               shadow_perm[free_slot]  = perm;
            end
         end
      end else if (op == OP_SEEK || op == OP_DESTROY) begin
         for (int i = 0; i < MaxRegions; i++) begin
            if (hit < 0 && shadow_valid[i] && addr >= shadow_base[i] && addr <= shadow_top[i])
               hit = i;
         end
         if (hit >= 0) begin
            ans = '{status: ST_OK, base: shadow_base[hit], top: shadow_top[hit],
                    perm: shadow_perm[hit]};
            if (op == OP_DESTROY)
               shadow_valid[hit] = 1'b0;
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [FieldW-1:0] want,
                                  input logic [FieldW-1:0] got);
      if (error_count < MaxPrinted)
         $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   // One request transfer; the prediction is taken at acceptance
   task automatic send_region_op(input logic [OpW-1:0] op, input logic [FieldW-1:0] addr,
                                 input logic [FieldW-1:0] size, input logic [PermW-1:0] perm);
      region_answer_type ans;
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.opcode      <= op;
      req_if.address     <= addr;
      req_if.region_size <= size;
      req_if.access_perm <= perm;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      ans = predict_region_op(op, addr, size, perm);
      expected_answers.push_back(ans);
      op_seen[op]++;
      status_seen[ans.status]++;
      items_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // Stop sending until every answer is back, then let the block settle
   task automatic wait_all_answered;
      idle_sender(1);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Destroy every region currently stored
   task automatic clear_regions;
      logic [FieldW-1:0] bases[$];
      for (int i = 0; i < MaxRegions; i++)
         if (shadow_valid[i]) bases.push_back(shadow_base[i]);
      foreach (bases[i])
         send_region_op(OP_DESTROY, bases[i], {$urandom, $urandom}, 3'($urandom));
   endtask

   // Field extremes, every opcode, overflow, overlap edges, check order
   task automatic test_directed_ops;
      send_region_op(OP_SEEK, '0, '0, '0);
      send_region_op(OP_DESTROY, '0, '0, '0);
      send_region_op(OP_DEFINE, '0, '0, 3'd0);
      send_region_op(OP_SEEK, '0, '1, 3'd7);
      send_region_op(OP_DEFINE, AddrMask, '0, 3'd7);
      send_region_op(OP_SEEK, AddrMask, '0, '0);
      send_region_op(OP_DEFINE, AddrMask, 64'd1, 3'd1);
      send_region_op(OP_DEFINE, 64'd1, '1, 3'd2);
      // overflow is checked before overlap
      send_region_op(OP_DEFINE, AddrMask, '1, 3'd3);
      send_region_op(OP_DEFINE, '0, AddrMask, 3'd4);
      send_region_op(OP_DEFINE, 64'h100, 64'hFF, 3'd5);
      // touching the top and the base both count as overlap
      send_region_op(OP_DEFINE, 64'h1FF, 64'h10, 3'd6);
      send_region_op(OP_DEFINE, 64'hF0, 64'h10, 3'd6);
      send_region_op(OP_DEFINE, 64'hF0, 64'hF, 3'd6);
      send_region_op(OP_SEEK, 64'h1FF, '0, '0);
      send_region_op(OP_SEEK, 64'h200, '0, '0);
      send_region_op(OpUnused, 64'h150, 64'h10, 3'd7);
      send_region_op(OpUnused, '1, '1, 3'd7);
      send_region_op(OP_DESTROY, 64'h150, '0, '0);
      send_region_op(OP_SEEK, 64'h150, '0, '0);
      send_region_op(OP_DEFINE, 64'h100, 64'hFF, 3'd2);
      send_region_op(OP_DEFINE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5554, 3'd1);
      send_region_op(OP_DESTROY, AddrMask, '0, '0);
      send_region_op(OP_DESTROY, '0, '0, '0);
      wait_all_answered();
   endtask

   // Fill every slot, then full, overlap-over-full and overflow-over-full
   task automatic test_table_full;
      logic [FieldW-1:0] start;
      logic [FieldW-1:0] stride;
      clear_regions();
      start  = {32'h0, $urandom};
      stride = $urandom_range(4096, 16);
      for (int i = 0; i < MaxRegions; i++)
         send_region_op(OP_DEFINE, start + i * stride, $urandom_range(stride - 1), 3'($urandom));
      send_region_op(OP_DEFINE, start + MaxRegions * stride, '0, 3'd7);
      send_region_op(OP_DEFINE, start, '0, 3'd7);
      send_region_op(OP_DEFINE, AddrMask, 64'd5, 3'd7);
      send_region_op(OP_DESTROY, start + 5 * stride, '0, '0);
      send_region_op(OP_DEFINE, start + 5 * stride, '0, 3'd3);
      send_region_op(OP_DEFINE, start + MaxRegions * stride, '0, 3'd7);
      clear_regions();
      wait_all_answered();
   endtask

   // Random request; define_pct steers the fill level of the table
   task automatic send_random_op(input logic [FieldW-1:0] window, input int define_pct);
      logic [FieldW-1:0] addr;
      logic [FieldW-1:0] size;
      logic [FieldW-1:0] span;
      logic [FieldW-1:0] off;
      logic [OpW-1:0]    op;
      int                live[$];
      int                pick;
      int                slot;
      pick = $urandom_range(99);
      size = {$urandom, $urandom};
      addr = {$urandom, $urandom};
      if (pick < 5) begin
         op = 2'($urandom);                 // noise over the whole field range
      end else if (pick < 8) begin
         op = OpUnused;
      end else if ($urandom_range(99) < define_pct) begin
         op   = OP_DEFINE;
         addr = window + $urandom_range(8191);
         size = ($urandom_range(15) == 0) ? $urandom_range(8191) : $urandom_range(511);
      end else begin
         op = ($urandom_range(4) < 3) ? OP_SEEK : OP_DESTROY;
         for (int i = 0; i < MaxRegions; i++)
            if (shadow_valid[i]) live.push_back(i);
         if (live.size() != 0 && $urandom_range(3) != 0) begin
            // aim inside a stored region
            slot = live[$urandom_range(live.size() - 1)];
            span = shadow_top[slot] - shadow_base[slot];
            off  = {$urandom, $urandom};
            if (span != AddrMask) off = off % (span + 1);
            addr = shadow_base[slot] + off;
         end else begin
            addr = window + $urandom_range(8191);
         end
      end
      send_region_op(op, addr, size, 3'($urandom));
   endtask

   // Receiver held off for a long stretch while requests keep coming
   task automatic test_backpressure;
      hold_request = HoldCycles;
      repeat (40) send_random_op('0, 60);
      wait_all_answered();
   endtask

   // Bursty random traffic in several address windows
   task automatic test_random_traffic;
      logic [FieldW-1:0] window;
      int                sent;
      int                burst;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase % 3)
            0: window = '0;
            1: window = {$urandom, $urandom} & ~64'hFFFF;
            default: window = AddrMask - 64'h1FFF;
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            burst = $urandom_range(24, 1);
            for (int b = 0; b < burst && sent < PhaseItems; b++) begin
               send_random_op(window, (phase % 2) ? 35 : 65);
               sent++;
            end
            if ($urandom_range(3) != 0)
               idle_sender($urandom_range(12, 1));
         end
      end
      wait_all_answered();
   endtask

   // Receiver: changing stall patterns, plus long hold-off on request
   initial begin : receiver
      int mode;
      int left;
      rsp_if.ready = 1'b0;
      mode         = 0;
      left         = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(3);
            left = $urandom_range(80, 10);
         end
         left--;
         if (hold_request > 0) begin
            hold_request--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom);
               2: rsp_if.ready <= ($urandom_range(3) == 0);
               default: rsp_if.ready <= (left % 5 != 0);
            endcase
         end
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin : answer_check
      region_answer_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            report_mismatch("response with nothing pending", '0, rsp_if.status);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", want.status, rsp_if.status);
            if (rsp_if.found_base !== want.base)
               report_mismatch("found_base", want.base, rsp_if.found_base);
            if (rsp_if.found_top !== want.top)
               report_mismatch("found_top", want.top, rsp_if.found_top);
            if (rsp_if.found_perm !== want.perm)
               report_mismatch("found_perm", want.perm, rsp_if.found_perm);
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = '0;
      req_if.address     = '0;
      req_if.region_size = '0;
      req_if.access_perm = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_table_full();
      test_backpressure();
      test_random_traffic();

      if (expected_answers.size() != 0)
         report_mismatch("answers never returned", '0, expected_answers.size());
      $display("Ran %0d requests (define %0d, seek %0d, destroy %0d, unused %0d), %0d responses.",
               items_sent, op_seen[OP_DEFINE], op_seen[OP_SEEK], op_seen[OP_DESTROY],
               op_seen[OpUnused], answers_seen);
      $display("Outcomes: ok %0d, overlap %0d, full %0d, no match %0d, overflow %0d; %0d errors.",
               status_seen[ST_OK], status_seen[ST_OVERLAP], status_seen[ST_FULL],
               status_seen[ST_NOMATCH], status_seen[ST_OVERFLOW], error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timeout: %0d answers still pending", expected_answers.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/art_pkg.sv
hdl/art_ifs.sv
hdl/art_ram.sv
hdl/address_region_table_unit.sv
tb/tb_top.sv
